/* rtl/scsa_pkg.sv */
// Shared constants, types and per-class tables of the slab allocator.
`timescale 1ns / 1ps
package scsa_pkg;

  localparam int NUM_CLASSES = 13;
  localparam int PAGE_BYTES  = 4096;
  localparam int POOL_PAGES  = 64;
  localparam int WORD_BYTES  = 4;
  localparam int MIN_OBJECTS = 8;

  localparam int POOL_WORDS       = POOL_PAGES * PAGE_BYTES / WORD_BYTES;
  localparam int AW               = $clog2(POOL_WORDS);
  localparam int LINK_W           = AW + 1;
  localparam int STORE_W          = 22;
  localparam int GUARD_BIT        = 21;
  localparam int VAL_W            = 21;
  localparam int CLS_W            = 4;
  localparam int PAGE_W           = 7;
  localparam int SIZE_W           = 15;
  localparam int REQ_W            = 20;
  localparam int HANDLE_W         = 32;
  localparam int LIM_W            = 15;
  localparam int SLOTW_W          = 13;
  localparam int OBJS_W           = 8;
  localparam int PC_W             = 6;
  localparam int REM_W            = 14;
  localparam int ADDR_W           = 18;
  localparam int WORD_SHIFT       = $clog2(WORD_BYTES);
  localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);
  localparam int PAGE_WORD_SHIFT  = PAGE_SHIFT - WORD_SHIFT;
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 15;

  localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_LIMIT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLACK_LIMIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REMAINDER_MIN = 2'd2;

  localparam logic [PAGE_W-1:0] PAGE_LIMIT_RST    = 7'd64;
  localparam logic [LIM_W-1:0]  SLACK_LIMIT_RST   = 15'd128;
  localparam logic [LIM_W-1:0]  REMAINDER_MIN_RST = 15'd512;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_FALLBACK  = 3'd2,
    ST_NO_PAGES  = 3'd3,
    ST_ZERO_SIZE = 3'd4
  } status_t;

  typedef struct packed {
    logic             zero;
    logic             fit;
    logic [CLS_W-1:0] idx;
  } cls_dec_t;

  function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] c);
    case (c)
      4'd0:    class_size = 15'd8;
      4'd1:    class_size = 15'd16;
      4'd2:    class_size = 15'd32;
      4'd3:    class_size = 15'd64;
      4'd4:    class_size = 15'd128;
      4'd5:    class_size = 15'd256;
      4'd6:    class_size = 15'd384;
      4'd7:    class_size = 15'd512;
      4'd8:    class_size = 15'd1024;
      4'd9:    class_size = 15'd2048;
      4'd10:   class_size = 15'd4096;
      4'd11:   class_size = 15'd8192;
      4'd12:   class_size = 15'd16384;
      default: class_size = '0;
    endcase
  endfunction

  // pages per refill: ceil(MIN_OBJECTS * size / PAGE_BYTES)
  function automatic logic [PC_W-1:0] class_pages(input logic [CLS_W-1:0] c);
    case (c)
      4'd8:    class_pages = 6'd2;
      4'd9:    class_pages = 6'd4;
      4'd10:   class_pages = 6'd8;
      4'd11:   class_pages = 6'd16;
      4'd12:   class_pages = 6'd32;
      default: class_pages = 6'd1;
    endcase
  endfunction

  // slot length in words: size plus three words
  function automatic logic [SLOTW_W-1:0] class_slot_words(input logic [CLS_W-1:0] c);
    class_slot_words = SLOTW_W'((class_size(c) >> WORD_SHIFT) + 3);
  endfunction

  function automatic logic [OBJS_W-1:0] class_objs(input logic [CLS_W-1:0] c);
    case (c)
      4'd0:    class_objs = 8'd204;
      4'd1:    class_objs = 8'd146;
      4'd2:    class_objs = 8'd93;
      4'd3:    class_objs = 8'd53;
      4'd4:    class_objs = 8'd29;
      4'd5:    class_objs = 8'd15;
      4'd6:    class_objs = 8'd10;
      default: class_objs = 8'd7;
    endcase
  endfunction

  function automatic logic [REM_W-1:0] class_rem(input logic [CLS_W-1:0] c);
    case (c)
      4'd0:    class_rem = 14'd16;
      4'd1:    class_rem = 14'd8;
      4'd2:    class_rem = 14'd4;
      4'd3:    class_rem = 14'd68;
      4'd4:    class_rem = 14'd36;
      4'd5:    class_rem = 14'd76;
      4'd6:    class_rem = 14'd136;
      4'd7:    class_rem = 14'd428;
      4'd8:    class_rem = 14'd940;
      4'd9:    class_rem = 14'd1964;
      4'd10:   class_rem = 14'd4012;
      4'd11:   class_rem = 14'd8108;
      4'd12:   class_rem = 14'd16300;
      default: class_rem = '0;
    endcase
  endfunction

endpackage

/* rtl/scsa_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/scsa_class.sv */
// Size class lookup: first fitting class and slack check.
`timescale 1ns / 1ps
module scsa_class (
  input  logic [scsa_pkg::REQ_W-1:0] req,
  input  logic [scsa_pkg::LIM_W-1:0] slack_limit,
  output scsa_pkg::cls_dec_t         dec
);

  logic                          found;
  logic [scsa_pkg::CLS_W-1:0]    idx;
  logic [scsa_pkg::REQ_W-1:0]    slack;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = 0; k < scsa_pkg::NUM_CLASSES; k++) begin
      if (!found && (scsa_pkg::REQ_W'(scsa_pkg::class_size(scsa_pkg::CLS_W'(k))) >= req)) begin
        found = 1'b1;
        idx   = scsa_pkg::CLS_W'(k);
      end
    end
    slack    = scsa_pkg::REQ_W'(scsa_pkg::class_size(idx)) - req;
    dec.zero = (req == '0);
    dec.fit  = found && (slack < scsa_pkg::REQ_W'(slack_limit));
    dec.idx  = idx;
  end

endmodule

/* rtl/size_class_slab_allocator.sv */
// Top level: sequencer of the size-class slab allocator over one slot RAM.
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | request_bytes, handle                   | operation
//  out_    | out | address, class_index, remainder_address, | status
//          |     | remainder_bytes, pages_in_use           |
//  cfg_    | in  | write enable, register index, data      | -
//
// Alloc from a non-empty list: S_DECODE, S_POP_RD, S_POP_LINK, S_POP_GUARD, S_POP_TAIL;
// free: S_DECODE, S_FREE_HDR, S_FREE_CLS; rejects end in S_DECODE, or in S_FREE_HDR or
// S_FREE_CLS when a free fails its guard or class check. A refill pushes up to 204 slots,
// one RAM write each. After reset a clearing pass writes all 65536 slot words, one per cycle.
// Input is held off while an item is in work or a result waits.
`timescale 1ns / 1ps
module size_class_slab_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [55:0]                         in_tdata,  // request_bytes, handle, pad
  input  logic                                in_tuser,  // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [63:0]                         out_tdata, // address, class_index,
                                                         // remainder_address,
                                                         // remainder_bytes, pages_in_use, pad
  output logic [2:0]                          out_tuser, // status
  input  logic                                cfg_we,
  input  logic [scsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW     = scsa_pkg::AW;
  localparam int LW     = scsa_pkg::LINK_W;
  localparam int SW     = scsa_pkg::STORE_W;
  localparam int CW     = scsa_pkg::CLS_W;
  localparam int PW     = scsa_pkg::PAGE_W;
  localparam int NC     = scsa_pkg::NUM_CLASSES;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FILL, S_POP_RD, S_POP_LINK,
    S_POP_GUARD, S_POP_TAIL, S_FREE_HDR, S_FREE_CLS
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]                    clr_r, clr_nxt;
  logic                             op_r, op_nxt;
  logic [scsa_pkg::REQ_W-1:0]       req_r, req_nxt;
  logic [scsa_pkg::HANDLE_W-1:0]    handle_r, handle_nxt;
  logic [CW-1:0]                    cls_r, cls_nxt;
  logic [LW-1:0]                    head_r [NC];
  logic [LW-1:0]                    head_nxt [NC];
  logic [PW-1:0]                    pages_r, pages_nxt;
  logic [LW-1:0]                    w_r, w_nxt;
  logic [scsa_pkg::OBJS_W-1:0]      j_r, j_nxt;
  logic [AW-1:0]                    area_r, area_nxt;
  logic [scsa_pkg::ADDR_W-1:0]      raddr_r, raddr_nxt;
  logic [scsa_pkg::REM_W-1:0]       rbytes_r, rbytes_nxt;
  logic [PW-1:0]                    page_limit_r;
  logic [scsa_pkg::LIM_W-1:0]       slack_limit_r, remainder_min_r;

  logic                             out_valid_r, out_valid_nxt;
  scsa_pkg::status_t                out_status_r, out_status_nxt;
  logic [scsa_pkg::ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic [CW-1:0]                    out_cls_r, out_cls_nxt;
  logic [scsa_pkg::ADDR_W-1:0]      out_raddr_r, out_raddr_nxt;
  logic [scsa_pkg::REM_W-1:0]       out_rbytes_r, out_rbytes_nxt;

  logic                             ram_we;
  logic [AW-1:0]                    ram_addr;
  logic [SW-1:0]                    ram_wdata, ram_rdata;

  scsa_pkg::cls_dec_t               dec;

  logic [PW-1:0]                    lim;
  logic [PW:0]                      page_sum;
  logic [scsa_pkg::PC_W-1:0]        pc;
  logic [scsa_pkg::REM_W-1:0]       rem;
  logic [19:0]                      raddr_calc;
  logic [29:0]                      hw;
  logic                             handle_ok;
  logic [AW-1:0]                    area_calc;
  logic [LW-1:0]                    head_cur;
  logic [CW-1:0]                    fcls;
  logic                             fcls_ok;
  logic [LW:0]                      tail;
  logic [AW-1:0]                    area_p2;
  logic                             fin;
  scsa_pkg::status_t                fin_status;
  logic [scsa_pkg::ADDR_W-1:0]      fin_addr;
  logic [CW-1:0]                    fin_cls;
  logic [scsa_pkg::ADDR_W-1:0]      fin_raddr;
  logic [scsa_pkg::REM_W-1:0]       fin_rbytes;

  scsa_class u_class (
    .req         (req_r),
    .slack_limit (slack_limit_r),
    .dec         (dec)
  );

  scsa_ram #(
    .WIDTH (SW),
    .DEPTH (scsa_pkg::POOL_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, pages_r, out_rbytes_r, out_raddr_r, out_cls_r, out_addr_r};

  assign lim        = (page_limit_r < PW'(scsa_pkg::POOL_PAGES)) ? page_limit_r
                                                                 : PW'(scsa_pkg::POOL_PAGES);
  assign pc         = scsa_pkg::class_pages(dec.idx);
  assign page_sum   = {1'b0, pages_r} + (PW + 1)'(pc);
  assign rem        = scsa_pkg::class_rem(dec.idx);
  assign raddr_calc = (20'(pages_r) << scsa_pkg::PAGE_SHIFT)
                    + (20'(pc) << scsa_pkg::PAGE_SHIFT) - 20'(rem);
  assign hw         = handle_r[31:2];
  assign handle_ok  = (handle_r[1:0] == 2'b00) && (hw >= 30'd2)
                    && (hw <= 30'(scsa_pkg::POOL_WORDS));
  assign area_calc  = AW'(hw - 30'd2);
  assign fcls       = ram_rdata[CW-1:0];
  assign fcls_ok    = !ram_rdata[scsa_pkg::GUARD_BIT]
                    && (ram_rdata[scsa_pkg::VAL_W-1:0] < scsa_pkg::VAL_W'(NC));
  assign head_cur   = head_r[cls_r];
  assign tail       = (LW + 1)'(area_r) + (LW + 1)'(scsa_pkg::class_slot_words(cls_r))
                    - (LW + 1)'(1);
  assign area_p2    = area_r + AW'(2);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    handle_nxt     = handle_r;
    cls_nxt        = cls_r;
    head_nxt       = head_r;
    pages_nxt      = pages_r;
    w_nxt          = w_r;
    j_nxt          = j_r;
    area_nxt       = area_r;
    raddr_nxt      = raddr_r;
    rbytes_nxt     = rbytes_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_cls_nxt    = out_cls_r;
    out_raddr_nxt  = out_raddr_r;
    out_rbytes_nxt = out_rbytes_r;
    ram_we         = 1'b0;
    ram_addr       = '0;
    ram_wdata      = '0;
    fin            = 1'b0;
    fin_status     = scsa_pkg::ST_FALLBACK;
    fin_addr       = '0;
    fin_cls        = '0;
    fin_raddr      = '0;
    fin_rbytes     = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt     = in_tuser;
          req_nxt    = in_tdata[19:0];
          handle_nxt = in_tdata[51:20];
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!op_r) begin
          raddr_nxt  = '0;
          rbytes_nxt = '0;
          cls_nxt    = dec.idx;
          if (dec.zero) begin
            fin        = 1'b1;
            fin_status = scsa_pkg::ST_ZERO_SIZE;
          end else if (!dec.fit) begin
            fin = 1'b1;
          end else if (head_r[dec.idx] != '0) begin
            state_nxt = S_POP_RD;
          end else if (page_sum > (PW + 1)'(lim)) begin
            fin        = 1'b1;
            fin_status = scsa_pkg::ST_NO_PAGES;
            fin_cls    = dec.idx;
          end else begin
            pages_nxt = page_sum[PW-1:0];
            w_nxt     = LW'(pages_r) << scsa_pkg::PAGE_WORD_SHIFT;
            j_nxt     = '0;
            if (scsa_pkg::LIM_W'(rem) >= remainder_min_r) begin
              raddr_nxt  = raddr_calc[scsa_pkg::ADDR_W-1:0];
              rbytes_nxt = rem;
            end
            state_nxt = S_FILL;
          end
        end else if (!handle_ok) begin
          fin = 1'b1;
        end else begin
          area_nxt  = area_calc;
          ram_addr  = area_calc + AW'(1);
          state_nxt = S_FREE_HDR;
        end
      end
      S_FILL: begin
        ram_we          = 1'b1;
        ram_addr        = w_r[AW-1:0];
        ram_wdata       = SW'(head_cur);
        head_nxt[cls_r] = w_r + LW'(1);
        w_nxt           = w_r + LW'(scsa_pkg::class_slot_words(cls_r));
        j_nxt           = j_r + scsa_pkg::OBJS_W'(1);
        if (j_r == scsa_pkg::class_objs(cls_r) - scsa_pkg::OBJS_W'(1)) begin
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        ram_addr  = AW'(head_cur - LW'(1));
        area_nxt  = AW'(head_cur - LW'(1));
        state_nxt = S_POP_LINK;
      end
      S_POP_LINK: begin
        head_nxt[cls_r] = ram_rdata[LW-1:0];
        ram_we          = 1'b1;
        ram_addr        = area_r;
        ram_wdata       = SW'(cls_r);
        state_nxt       = S_POP_GUARD;
      end
      S_POP_GUARD: begin
        ram_we    = 1'b1;
        ram_addr  = area_r + AW'(1);
        ram_wdata = SW'(1) << scsa_pkg::GUARD_BIT;
        state_nxt = S_POP_TAIL;
      end
      S_POP_TAIL: begin
        ram_we     = (tail < (LW + 1)'(scsa_pkg::POOL_WORDS));
        ram_addr   = tail[AW-1:0];
        ram_wdata  = SW'(1) << scsa_pkg::GUARD_BIT;
        fin        = 1'b1;
        fin_status = scsa_pkg::ST_ALLOCATED;
        fin_addr   = {area_p2, 2'b00};
        fin_cls    = cls_r;
        fin_raddr  = raddr_r;
        fin_rbytes = rbytes_r;
      end
      S_FREE_HDR: begin
        if (!ram_rdata[scsa_pkg::GUARD_BIT]) begin
          fin = 1'b1;
        end else begin
          ram_addr  = area_r;
          state_nxt = S_FREE_CLS;
        end
      end
      S_FREE_CLS: begin
        fin = 1'b1;
        if (fcls_ok) begin
          ram_we         = 1'b1;
          ram_addr       = area_r;
          ram_wdata      = SW'(head_r[fcls]);
          head_nxt[fcls] = LW'(area_r) + LW'(1);
          fin_status     = scsa_pkg::ST_FREED;
          fin_cls        = fcls;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_addr_nxt   = fin_addr;
      out_cls_nxt    = fin_cls;
      out_raddr_nxt  = fin_raddr;
      out_rbytes_nxt = fin_rbytes;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      pages_r         <= '0;
      out_valid_r     <= 1'b0;
      page_limit_r    <= scsa_pkg::PAGE_LIMIT_RST;
      slack_limit_r   <= scsa_pkg::SLACK_LIMIT_RST;
      remainder_min_r <= scsa_pkg::REMAINDER_MIN_RST;
      for (int k = 0; k < NC; k++) begin
        head_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pages_r     <= pages_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          scsa_pkg::CFG_PAGE_LIMIT:    page_limit_r    <= cfg_wdata[PW-1:0];
          scsa_pkg::CFG_SLACK_LIMIT:   slack_limit_r   <= cfg_wdata;
          scsa_pkg::CFG_REMAINDER_MIN: remainder_min_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    handle_r     <= handle_nxt;
    cls_r        <= cls_nxt;
    w_r          <= w_nxt;
    j_r          <= j_nxt;
    area_r       <= area_nxt;
    raddr_r      <= raddr_nxt;
    rbytes_r     <= rbytes_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_cls_r    <= out_cls_nxt;
    out_raddr_r  <= out_raddr_nxt;
    out_rbytes_r <= out_rbytes_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> ram_we)
    else $error("fill cycle without slot write");

  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_r <= PW'(scsa_pkg::POOL_PAGES))
    else $error("pages in use beyond pool");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result pending while sequencer busy");
`endif

endmodule
